FILE: hdl/lfuc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_pkg
// shared types and constants of the lfu tag store: controller commands,
// datapath status and fixed field widths
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned LIMIT_W    = 5;
  localparam int unsigned OUT_FREQ_W = 16;
  localparam int unsigned TOTAL_W    = 32;

  localparam logic [LIMIT_W-1:0]    LIMIT_RESET  = 5'd16;
  localparam logic [OUT_FREQ_W-1:0] OUT_FREQ_MAX = 16'hFFFF;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture lookup key
    logic commit;     // hit update or plain insert, no victim search
    logic scan_init;  // clear victim search
    logic scan_step;  // examine one entry
    logic evict;      // insert after victim search
  } lfuc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_evict;
    logic scan_last;
  } lfuc_status_t;

endpackage

FILE: hdl/lfuc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_ctrl
// sequencer of the lfu tag store: match, optional victim scan, commit
// ----------------------------------------------------------------------------
module lfuc_ctrl
  import lfuc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  lfuc_status_t status_i,
  output lfuc_cmd_t    cmd_o,
  output logic         busy,
  output logic         done_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_EVICT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // commands depend on state, start and datapath status
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_MATCH: begin
        cmd_o.commit    = !status_i.need_evict;
        cmd_o.scan_init = status_i.need_evict;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_EVICT: begin
        cmd_o.evict = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= ST_MATCH;
            busy_q  <= 1'b1;
          end
        end
        ST_MATCH: begin
          if (status_i.need_evict) begin
            state_q <= ST_SCAN;
            done_q  <= 1'b0;
          end else begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        ST_SCAN: begin
          done_q <= 1'b0;
          if (status_i.scan_last) begin
            state_q <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

FILE: hdl/lfuc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_dpath
// entry store with parallel key match, sequential victim scan, counters and
// result registers
// ----------------------------------------------------------------------------
module lfuc_dpath
  import lfuc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16,
  parameter int unsigned FREQ_BITS     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfuc_cmd_t             cmd_i,
  output lfuc_status_t          status_o,
  input  logic                  cfg_we_i,
  input  logic [LIMIT_W-1:0]    cfg_wdata_i,
  input  logic [KEY_W-1:0]      lookup_key_i,
  output logic                  was_hit_o,
  output logic                  did_evict_o,
  output logic [KEY_W-1:0]      evicted_key_o,
  output logic [OUT_FREQ_W-1:0] new_frequency_o,
  output logic [TOTAL_W-1:0]    total_hits_o,
  output logic [TOTAL_W-1:0]    total_misses_o
);

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
  localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};
  localparam logic [FREQ_BITS-1:0] FREQ_ONE = FREQ_BITS'(1);

  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [KEY_W-1:0]         key_q  [CACHE_ENTRIES];
  logic [FREQ_BITS-1:0]     freq_q [CACHE_ENTRIES];
  logic [OCC_W-1:0]         occ_q;
  logic [LIMIT_W-1:0]       limit_q;
  logic [KEY_W-1:0]         lookup_q;
  logic [TOTAL_W-1:0]       hits_q;
  logic [TOTAL_W-1:0]       misses_q;

  logic [IDX_W-1:0]         scan_idx_q;
  logic                     best_v_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic [KEY_W-1:0]         best_key_q;
  logic [FREQ_BITS-1:0]     best_freq_q;

  // ---- key match ----
  logic [CACHE_ENTRIES-1:0] match;
  logic [FREQ_BITS-1:0]     freq_inc [CACHE_ENTRIES];
  logic [FREQ_BITS-1:0]     hit_freq;
  logic                     hit;

  always_comb begin
    hit_freq = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      match[i]    = valid_q[i] && (key_q[i] == lookup_q);
      freq_inc[i] = (freq_q[i] == FREQ_MAX) ? freq_q[i] : freq_q[i] + FREQ_ONE;
      hit_freq    = hit_freq | (match[i] ? freq_inc[i] : '0);
    end
  end

  assign hit = |match;

  // effective capacity limit, clamped to one and to the store size
  logic [CMP_W-1:0] limit_ext;
  logic [CMP_W-1:0] limit_eff;

  always_comb begin
    limit_ext = CMP_W'(limit_q);
    if (limit_ext == '0) begin
      limit_eff = CMP_W'(1);
    end else if (limit_ext > CMP_W'(CACHE_ENTRIES)) begin
      limit_eff = CMP_W'(CACHE_ENTRIES);
    end else begin
      limit_eff = limit_ext;
    end
  end

  assign status_o.need_evict = !hit && (CMP_W'(occ_q) >= limit_eff);
  assign status_o.scan_last  = (scan_idx_q == IDX_W'(CACHE_ENTRIES - 1));

  // ---- victim scan, one entry a cycle ----
  logic [KEY_W-1:0]     scan_key;
  logic [FREQ_BITS-1:0] scan_freq;
  logic                 scan_take;

  assign scan_key  = key_q[scan_idx_q];
  assign scan_freq = freq_q[scan_idx_q];
  assign scan_take = valid_q[scan_idx_q] &&
                     (!best_v_q || (scan_freq < best_freq_q) ||
                      ((scan_freq == best_freq_q) && (scan_key < best_key_q)));

  // ---- insertion slot ----
  logic                     victim_en;
  logic                     insert_en;
  logic                     hit_en;
  logic [CACHE_ENTRIES-1:0] valid_eff;
  logic [CACHE_ENTRIES-1:0] valid_d;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  assign victim_en = cmd_i.evict && best_v_q;
  assign hit_en    = cmd_i.commit && hit;
  assign insert_en = (cmd_i.commit && !hit) || cmd_i.evict;

  always_comb begin
    valid_eff = valid_q;
    if (victim_en) begin
      valid_eff[best_idx_q] = 1'b0;
    end
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_eff[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
    valid_d = valid_eff;
    if (free_found) begin
      valid_d[free_idx] = 1'b1;
    end
  end

  // reported frequency saturates at the output width
  logic [31:0]           hit_freq_ext;
  logic [OUT_FREQ_W-1:0] hit_freq_out;

  assign hit_freq_ext = 32'(hit_freq);
  assign hit_freq_out = (hit_freq_ext > 32'(OUT_FREQ_MAX)) ? OUT_FREQ_MAX
                                                           : hit_freq_ext[OUT_FREQ_W-1:0];

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      occ_q    <= '0;
      limit_q  <= LIMIT_RESET;
      hits_q   <= '0;
      misses_q <= '0;
      best_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.scan_init) begin
        best_v_q <= 1'b0;
      end else if (cmd_i.scan_step && scan_take) begin
        best_v_q <= 1'b1;
      end
      if (hit_en) begin
        hits_q <= hits_q + TOTAL_W'(1);
      end
      if (insert_en) begin
        misses_q <= misses_q + TOTAL_W'(1);
        valid_q  <= valid_d;
        if (victim_en && !free_found) begin
          occ_q <= occ_q - OCC_W'(1);
        end else if (!victim_en && free_found) begin
          occ_q <= occ_q + OCC_W'(1);
        end
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lookup_q <= lookup_key_i;
    end
    if (cmd_i.scan_init) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + IDX_W'(1);
      if (scan_take) begin
        best_idx_q  <= scan_idx_q;
        best_key_q  <= scan_key;
        best_freq_q <= scan_freq;
      end
    end
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (hit_en && match[i]) begin
        freq_q[i] <= freq_inc[i];
      end else if (insert_en && free_found && (free_idx == IDX_W'(i))) begin
        key_q[i]  <= lookup_q;
        freq_q[i] <= FREQ_ONE;
      end
    end
    if (hit_en) begin
      was_hit_o       <= 1'b1;
      did_evict_o     <= 1'b0;
      evicted_key_o   <= '0;
      new_frequency_o <= hit_freq_out;
      total_hits_o    <= hits_q + TOTAL_W'(1);
      total_misses_o  <= misses_q;
    end else if (insert_en) begin
      was_hit_o       <= 1'b0;
      did_evict_o     <= victim_en;
      evicted_key_o   <= victim_en ? best_key_q : '0;
      new_frequency_o <= OUT_FREQ_W'(1);
      total_hits_o    <= hits_q;
      total_misses_o  <= misses_q + TOTAL_W'(1);
    end
  end

endmodule

FILE: hdl/lfu_fully_associative_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_fully_associative_cache
// fully associative tag store with least-frequently-used replacement and
// running hit and miss totals
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  --------  --------------------  ---------------------------------------
//  request   start, busy           lookup_key_i
//  result    done_o (one cycle)    was_hit_o, did_evict_o, evicted_key_o,
//                                  new_frequency_o, total_hits_o,
//                                  total_misses_o
//  config    cfg_we_i              cfg_wdata_i (capacity limit)
//
//  a transfer in is taken when start is high and busy is low; a hit or a miss
//  with a free slot passes through the match state, and done_o rises as the
//  sequencer returns from match to idle
//  a miss at the capacity limit adds a victim scan of one entry per cycle and
//  an evict commit state before the return to idle
//  a new transfer may be taken in the cycle the result is shown
//  the receiver cannot stall: each result is valid for exactly one cycle
//  reset clears all valid bits, occupancy and totals at once; no sweep
//
// ----------------------------------------------------------------------------
module lfu_fully_associative_cache
  import lfuc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16,
  parameter int unsigned FREQ_BITS     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request transfer
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_W-1:0]      lookup_key_i,
  // configuration write
  input  logic                  cfg_we_i,
  input  logic [LIMIT_W-1:0]    cfg_wdata_i,
  // result transfer
  output logic                  done_o,
  output logic                  was_hit_o,
  output logic                  did_evict_o,
  output logic [KEY_W-1:0]      evicted_key_o,
  output logic [OUT_FREQ_W-1:0] new_frequency_o,
  output logic [TOTAL_W-1:0]    total_hits_o,
  output logic [TOTAL_W-1:0]    total_misses_o
);

  lfuc_cmd_t    cmd;
  lfuc_status_t status;

  // sequencer: idle, match, victim scan, evict commit
  lfuc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // entry store, parallel match, scan registers and result registers
  lfuc_dpath #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .FREQ_BITS     (FREQ_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .lookup_key_i    (lookup_key_i),
    .was_hit_o       (was_hit_o),
    .did_evict_o     (did_evict_o),
    .evicted_key_o   (evicted_key_o),
    .new_frequency_o (new_frequency_o),
    .total_hits_o    (total_hits_o),
    .total_misses_o  (total_misses_o)
  );

  // an accepted transfer keeps the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transfer");

  // a result is shown only once the block is free again
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // an eviction happens only on a miss
  a_evict_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && did_evict_o) |-> !was_hit_o)
    else $error("eviction reported on a hit");

  // evicted key is zero when nothing was displaced
  a_evict_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !did_evict_o) |-> (evicted_key_o == '0))
    else $error("evicted key nonzero without eviction");

endmodule

FILE: tb/tb_lfu_fully_associative_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfu_fully_associative_cache
// self-checking bench for the lfu tag store: a clocked driver sends lookup
// keys from a backlog in bursts, a clocked monitor checks every result against
// a cycle-free least-frequently-used model kept alongside, and the capacity
// limit is rewritten between phases while the block is idle
// ----------------------------------------------------------------------------
module tb_lfu_fully_associative_cache;
  import lfuc_pkg::*;

  localparam int unsigned CACHE_ENTRIES  = 16;
  localparam int unsigned FREQ_BITS      = 16;
  // slowest lookup is a miss with a victim scan
  localparam int unsigned SETTLE_CYCLES  = CACHE_ENTRIES + 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // one expected lookup outcome, laid out like the result ports
  typedef struct packed {
    logic                  hit;
    logic                  evict;
    logic [KEY_W-1:0]      evicted_key;
    logic [OUT_FREQ_W-1:0] frequency;
    logic [TOTAL_W-1:0]    hits;
    logic [TOTAL_W-1:0]    misses;
  } lookup_outcome_t;

  // dut ports, all inputs known from time zero
  logic                  clk_i;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic                  busy;
  logic [KEY_W-1:0]      lookup_key_i = '0;
  logic                  cfg_we_i     = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata_i  = '0;
  logic                  done_o;
  logic                  was_hit_o;
  logic                  did_evict_o;
  logic [KEY_W-1:0]      evicted_key_o;
  logic [OUT_FREQ_W-1:0] new_frequency_o;
  logic [TOTAL_W-1:0]    total_hits_o;
  logic [TOTAL_W-1:0]    total_misses_o;

  // tag store model: slots, occupancy, totals and the capacity register
  logic                  slot_valid [CACHE_ENTRIES] = '{default: 1'b0};
  logic [KEY_W-1:0]      slot_key   [CACHE_ENTRIES] = '{default: '0};
  logic [FREQ_BITS-1:0]  slot_freq  [CACHE_ENTRIES] = '{default: '0};
  int unsigned           fill_count   = 0;
  logic [TOTAL_W-1:0]    hit_count    = '0;
  logic [TOTAL_W-1:0]    miss_count   = '0;
  logic [LIMIT_W-1:0]    capacity_reg = LIMIT_RESET;

  // keys waiting to be sent, and outcomes waiting for their result transfer
  logic [KEY_W-1:0]      key_backlog [$];
  lookup_outcome_t       lookup_outcomes [$];

  int unsigned           burst_left   = 0;
  int unsigned           gap_left     = 0;
  int unsigned           stall_cycles = 0;
  int unsigned           mismatches   = 0;
  int unsigned           result_count = 0;

  lfu_fully_associative_cache #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .FREQ_BITS     (FREQ_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .lookup_key_i    (lookup_key_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .was_hit_o       (was_hit_o),
    .did_evict_o     (did_evict_o),
    .evicted_key_o   (evicted_key_o),
    .new_frequency_o (new_frequency_o),
    .total_hits_o    (total_hits_o),
    .total_misses_o  (total_misses_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // one lookup against the model; updates the store and returns the outcome
  function automatic lookup_outcome_t lfu_lookup(input logic [KEY_W-1:0] key);
    lookup_outcome_t res;
    int              slot;
    int              victim;
    int              free_slot;
    int unsigned     cap;
    res       = '0;
    slot      = -1;
    victim    = -1;
    free_slot = -1;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (slot < 0 && slot_valid[i] && slot_key[i] == key) slot = i;
    end
    if (slot >= 0) begin
      res.hit = 1'b1;
      hit_count++;
      // count sticks at all ones
      if (slot_freq[slot] != '1) slot_freq[slot]++;
      res.frequency = OUT_FREQ_W'(slot_freq[slot]);
    end else begin
      miss_count++;
      // a limit of zero behaves as one, anything past the store as the store
      cap = (capacity_reg == 0) ? 1 :
            (capacity_reg > CACHE_ENTRIES) ? CACHE_ENTRIES : capacity_reg;
      if (fill_count >= cap) begin
        // lowest count wins, ties to the smallest key
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_freq[i] < slot_freq[victim] ||
              (slot_freq[i] == slot_freq[victim] && slot_key[i] < slot_key[victim])))
            victim = i;
        end
        if (victim >= 0) begin
          res.evict         = 1'b1;
          res.evicted_key   = slot_key[victim];
          slot_valid[victim] = 1'b0;
          slot_key[victim]   = '0;
          slot_freq[victim]  = '0;
          fill_count--;
        end
      end
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (free_slot < 0 && !slot_valid[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot]   = key;
        slot_freq[free_slot]  = FREQ_BITS'(1);
        fill_count++;
      end
      res.frequency = OUT_FREQ_W'(1);
    end
    res.hits   = hit_count;
    res.misses = miss_count;
    return res;
  endfunction

  // driver: bursts of random length from the backlog, random gaps in between
  // a gap of zero still leaves start low for one cycle, so start is never
  // lowered and raised at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // the capacity register follows the write at the edge that takes it
      if (cfg_we_i) capacity_reg = cfg_wdata_i;
      if (start && !busy) begin
        lookup_outcomes = {lookup_outcomes, lfu_lookup(lookup_key_i)};
        if (burst_left > 0) burst_left--;
        if (burst_left > 0 && key_backlog.size() > 0) begin
          // keep start high, next key in the same burst
          lookup_key_i <= key_backlog.pop_front();
        end else begin
          start    <= 1'b0;
          gap_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (key_backlog.size() > 0) begin
          burst_left    = $urandom_range(1, 16);
          start        <= 1'b1;
          lookup_key_i <= key_backlog.pop_front();
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t ns result %0d: %s expected %h got %h",
                 $time, result_count, name, want, got);
    end
  endtask

  // monitor: every done_o pulse is one result transfer, checked in order
  always @(posedge clk_i) begin
    lookup_outcome_t want;
    if (rst_ni && done_o) begin
      if (lookup_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t ns result %0d: no lookup outstanding", $time, result_count);
      end else begin
        want = lookup_outcomes.pop_front();
        check_field("was_hit",       32'(want.hit),         32'(was_hit_o));
        check_field("did_evict",     32'(want.evict),       32'(did_evict_o));
        check_field("evicted_key",   want.evicted_key,      evicted_key_o);
        check_field("new_frequency", 32'(want.frequency),   32'(new_frequency_o));
        check_field("total_hits",    want.hits,             total_hits_o);
        check_field("total_misses",  want.misses,           total_misses_o);
      end
      result_count++;
    end
  end

  // watchdog: cycles with no transfer of any kind
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_lfu_fully_associative_cache failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // settled check at the falling edge, so nothing is still in flight at an edge
  task automatic wait_idle();
    do @(negedge clk_i);
    while (key_backlog.size() != 0 || start || lookup_outcomes.size() != 0);
  endtask

  task automatic write_capacity(input logic [LIMIT_W-1:0] limit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // a hot set of keys picked with a skew toward the low indexes, so counts
  // spread out and ties and evictions happen, plus some fully random keys
  task automatic queue_random_phase(input int unsigned count);
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] key;
    int unsigned      pool_size;
    int unsigned      roll;
    int unsigned      a;
    int unsigned      b;
    pool_size = $urandom_range(2, 24);
    repeat (pool_size) begin
      roll = $urandom_range(0, 7);
      key  = $urandom;
      if (roll == 0) key = '0;
      else if (roll == 1) key = '1;
      pool = {pool, key};
    end
    repeat (count) begin
      if ($urandom_range(0, 99) < 80) begin
        a = $urandom_range(0, pool_size - 1);
        b = $urandom_range(0, pool_size - 1);
        key_backlog = {key_backlog, pool[(a < b) ? a : b]};
      end else begin
        key_backlog = {key_backlog, KEY_W'($urandom)};
      end
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limits [7];
    phase_limits = '{5'd5, 5'd16, 5'd1, 5'd31, 5'd2, 5'd20, 5'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // limit of zero right after reset acts as one: each miss after the first swaps the entry
    write_capacity(5'd0);
    key_backlog = {key_backlog, 32'h0000_0000};
    key_backlog = {key_backlog, 32'hFFFF_FFFF};
    key_backlog = {key_backlog, 32'hFFFF_FFFF};
    key_backlog = {key_backlog, 32'h0000_0000};
    wait_idle();

    // small limit: fill, bump counts, then evict the least used
    write_capacity(5'd3);
    key_backlog = {key_backlog, 32'h0000_0001};
    key_backlog = {key_backlog, 32'h0000_0002};
    key_backlog = {key_backlog, 32'h0000_0002};
    key_backlog = {key_backlog, 32'h0000_0001};
    key_backlog = {key_backlog, 32'h0000_0001};
    key_backlog = {key_backlog, 32'h8000_0000};
    key_backlog = {key_backlog, 32'h7FFF_FFFF};
    wait_idle();

    // limit above the store acts as the full store; fill it, then a tie
    // among count-one entries goes to the smallest key
    write_capacity(5'd31);
    for (int i = 0; i < 13; i++) key_backlog = {key_backlog, KEY_W'(32'h5555_0000 + i)};
    key_backlog = {key_backlog, 32'hAAAA_AAAA};
    wait_idle();

    // random phases; the store is full from here on, so every lower limit
    // also covers a limit lowered below occupancy
    foreach (phase_limits[p]) begin
      write_capacity(phase_limits[p]);
      queue_random_phase(110);
      wait_idle();
    end
    write_capacity(LIMIT_W'($urandom_range(0, 31)));
    queue_random_phase(130);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && lookup_outcomes.size() == 0) begin
      $display("tb_lfu_fully_associative_cache passed");
    end else begin
      $display("tb_lfu_fully_associative_cache failed");
    end
    $finish;
  end

endmodule
